// File: rtl/core/lgtr_pkg.sv
// lgtr_pkg: shared types, constants and codes of the lda gibbs topic resampler
// transaction structs, controller state codes, command and status bundles
// depends on nothing
package lgtr_pkg;

  // fixed field widths
  localparam int TOPIC_W  = 4;
  localparam int TOKEN_W  = 16;
  localparam int DOC_W    = 10;
  localparam int TERM_W   = 12;
  localparam int FRAC_W   = 16;
  localparam int PRIOR_W  = 16;
  localparam int KCFG_W   = 5;
  localparam int VCFG_W   = 13;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int TOTAL_W  = 24;
  localparam int WEIGHT_W = 48;
  localparam int FRAC_SHIFT = 12;

  // parameter defaults
  localparam int DEF_MAX_TOPICS = 16;
  localparam int DEF_MAX_TERMS  = 4096;
  localparam int DEF_MAX_DOCS   = 1024;
  localparam int DEF_MAX_TOKENS = 65536;
  localparam int DEF_COUNT_BITS = 16;

  // register reset values
  localparam logic [KCFG_W-1:0]  RST_TOPICS = 5'd16;
  localparam logic [VCFG_W-1:0]  RST_TERMS  = 13'd4096;
  localparam logic [PRIOR_W-1:0] RST_ALPHA  = 16'd4096;
  localparam logic [PRIOR_W-1:0] RST_BETA   = 16'd410;

  localparam logic ACT_INIT     = 1'b0;
  localparam logic ACT_RESAMPLE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOPICS = 2'd0,
    CFG_TERMS  = 2'd1,
    CFG_ALPHA  = 2'd2,
    CFG_BETA   = 2'd3
  } lgtr_cfg_idx_t;

  typedef struct packed {
    logic               action;
    logic [TOKEN_W-1:0] token_index;
    logic [DOC_W-1:0]   doc_index;
    logic [TERM_W-1:0]  term_index;
    logic [FRAC_W-1:0]  random_fraction;
  } lgtr_in_t;

  typedef struct packed {
    logic [TOPIC_W-1:0] new_topic;
    logic [TOPIC_W-1:0] old_topic;
  } lgtr_out_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_TOK_RD, S_OLD_LD, S_REM_RD, S_REM_WR,
    S_W_RD, S_W_LOAD, S_W_MUL_LO, S_W_MUL_HI, S_W_DIV_LD, S_W_DIV, S_W_ACC,
    S_THR_MUL, S_THR_ADD, S_SEARCH, S_INIT, S_ADD_RD, S_ADD_WR, S_DONE
  } lgtr_state_t;

  // which topic addresses the count stores
  typedef enum logic [1:0] {
    TSEL_OLD = 2'd0,
    TSEL_K   = 2'd1,
    TSEL_NEW = 2'd2
  } lgtr_tsel_t;

  typedef struct packed {
    logic       latch_in;
    logic       clr_wr;
    logic       old_ld;
    logic       init_calc;
    lgtr_tsel_t tsel;
    logic       cnt_wr;
    logic       cnt_inc;
    logic       tok_wr;
    logic       k_clr;
    logic       w_load;
    logic       mul_lo;
    logic       mul_hi;
    logic       div_load;
    logic       div_step;
    logic       w_store;
    logic       thr_mul;
    logic       thr_add;
    logic       srch_step;
  } lgtr_cmd_t;

  typedef struct packed {
    logic is_resample;
    logic clear_done;
    logic div_last;
    logic k_last;
    logic hit;
  } lgtr_status_t;

endpackage

// File: rtl/core/lgtr_ctrl.sv
// lgtr_ctrl: sequencer of the topic resampler
// walks clear, remove, weigh, threshold, search, init and add phases
// depends on lgtr_pkg
module lgtr_ctrl import lgtr_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  lgtr_status_t sts,
  output lgtr_cmd_t    cmd,
  output logic         busy,
  output logic         out_valid
);

  lgtr_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:    if (sts.clear_done) state_nxt = S_IDLE;
      S_IDLE:     if (start) state_nxt = S_TOK_RD;
      S_TOK_RD:   state_nxt = sts.is_resample ? S_OLD_LD : S_INIT;
      S_OLD_LD:   state_nxt = S_REM_RD;
      S_REM_RD:   state_nxt = S_REM_WR;
      S_REM_WR:   state_nxt = S_W_RD;
      S_W_RD:     state_nxt = S_W_LOAD;
      S_W_LOAD:   state_nxt = S_W_MUL_LO;
      S_W_MUL_LO: state_nxt = S_W_MUL_HI;
      S_W_MUL_HI: state_nxt = S_W_DIV_LD;
      S_W_DIV_LD: state_nxt = S_W_DIV;
      S_W_DIV:    if (sts.div_last) state_nxt = S_W_ACC;
      S_W_ACC:    state_nxt = sts.k_last ? S_THR_MUL : S_W_RD;
      S_THR_MUL:  state_nxt = S_THR_ADD;
      S_THR_ADD:  state_nxt = S_SEARCH;
      S_SEARCH:   if (sts.hit) state_nxt = S_ADD_RD;
      S_INIT:     state_nxt = S_ADD_RD;
      S_ADD_RD:   state_nxt = S_ADD_WR;
      S_ADD_WR:   state_nxt = S_DONE;
      S_DONE:     state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // command decode
  always_comb begin
    cmd       = '0;
    cmd.tsel  = TSEL_K;
    busy      = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      S_CLEAR:    cmd.clr_wr = 1'b1;
      S_IDLE: begin
        busy         = 1'b0;
        cmd.latch_in = start;
      end
      S_TOK_RD:   ;
      S_OLD_LD:   cmd.old_ld = 1'b1;
      S_REM_RD:   cmd.tsel = TSEL_OLD;
      S_REM_WR: begin
        cmd.tsel   = TSEL_OLD;
        cmd.cnt_wr = 1'b1;
        cmd.k_clr  = 1'b1;
      end
      S_W_RD:     ;
      S_W_LOAD:   cmd.w_load = 1'b1;
      S_W_MUL_LO: cmd.mul_lo = 1'b1;
      S_W_MUL_HI: cmd.mul_hi = 1'b1;
      S_W_DIV_LD: cmd.div_load = 1'b1;
      S_W_DIV:    cmd.div_step = 1'b1;
      S_W_ACC:    cmd.w_store = 1'b1;
      S_THR_MUL: begin
        cmd.thr_mul = 1'b1;
        cmd.k_clr   = 1'b1;
      end
      S_THR_ADD:  cmd.thr_add = 1'b1;
      S_SEARCH:   cmd.srch_step = 1'b1;
      S_INIT:     cmd.init_calc = 1'b1;
      S_ADD_RD:   cmd.tsel = TSEL_NEW;
      S_ADD_WR: begin
        cmd.tsel    = TSEL_NEW;
        cmd.cnt_wr  = 1'b1;
        cmd.cnt_inc = 1'b1;
        cmd.tok_wr  = 1'b1;
      end
      S_DONE:     out_valid = 1'b1;
      default:    ;
    endcase
  end

endmodule

// File: rtl/core/lgtr_dpath.sv
// lgtr_dpath: count stores, token store, weight unit with serial divider,
// threshold and cumulative search of the topic resampler
// depends on lgtr_pkg
module lgtr_dpath import lgtr_pkg::*; #(
  parameter int MAX_TOPICS = DEF_MAX_TOPICS,
  parameter int MAX_TERMS  = DEF_MAX_TERMS,
  parameter int MAX_DOCS   = DEF_MAX_DOCS,
  parameter int MAX_TOKENS = DEF_MAX_TOKENS,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lgtr_cmd_t             cmd,
  output lgtr_status_t          sts,
  input  lgtr_in_t              in_data,
  input  logic                  cfg_wr,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output lgtr_out_t             out_data
);

  localparam int TW    = $clog2(MAX_TOPICS);
  localparam int KNW   = TW + 1;
  localparam int DAW   = (MAX_DOCS > 1) ? $clog2(MAX_DOCS) : 1;
  localparam int TMW   = $clog2(MAX_TERMS);
  localparam int TKW   = $clog2(MAX_TOKENS);
  localparam int DTAW  = DAW + TW;
  localparam int TTAW  = TW + TMW;
  localparam int CLRW  = (DTAW > TTAW) ? DTAW : TTAW;
  localparam int AW    = COUNT_BITS + FRAC_SHIFT + 1;
  localparam int HB    = AW / 2;
  localparam int NW    = 2 * AW;
  localparam int VBW   = VCFG_W + PRIOR_W;
  localparam int DENW  = TOTAL_W + FRAC_SHIFT + 1;
  localparam int QW    = (NW > WEIGHT_W) ? NW : WEIGHT_W;
  localparam int TSW   = WEIGHT_W + TW;
  localparam int DCW   = $clog2(NW);
  localparam logic [WEIGHT_W-1:0] WMAX = '1;

  // configuration registers
  logic [KCFG_W-1:0]  topics_r;
  logic [VCFG_W-1:0]  terms_r;
  logic [PRIOR_W-1:0] alpha_r, beta_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      topics_r <= RST_TOPICS;
      terms_r  <= RST_TERMS;
      alpha_r  <= RST_ALPHA;
      beta_r   <= RST_BETA;
    end else if (cfg_wr) begin
      unique case (lgtr_cfg_idx_t'(cfg_index))
        CFG_TOPICS: topics_r <= cfg_data[KCFG_W-1:0];
        CFG_TERMS:  terms_r  <= cfg_data[VCFG_W-1:0];
        CFG_ALPHA:  alpha_r  <= cfg_data;
        CFG_BETA:   beta_r   <= cfg_data;
      endcase
    end
  end

  // active topic count, clamped to 1..MAX_TOPICS
  logic [KNW-1:0] kn;
  always_comb begin
    if (topics_r == '0) begin
      kn = KNW'(1);
    end else if (32'(topics_r) > MAX_TOPICS) begin
      kn = KNW'(MAX_TOPICS);
    end else begin
      kn = KNW'(topics_r);
    end
  end

  // latched transaction
  logic              act_r;
  logic [TKW-1:0]    tok_r;
  logic [DAW-1:0]    doc_r;
  logic [TMW-1:0]    term_r;
  logic [FRAC_W-1:0] u_r;
  logic [VBW-1:0]    vb_r;

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      act_r  <= in_data.action;
      tok_r  <= TKW'(in_data.token_index);
      doc_r  <= DAW'(in_data.doc_index) & DAW'(MAX_DOCS - 1);
      term_r <= TMW'(in_data.term_index);
      u_r    <= in_data.random_fraction;
      vb_r   <= terms_r * beta_r;
    end
  end

  logic [TW-1:0] old_r, new_r, k_r;
  logic [TW-1:0] tsel_k;

  // topic that addresses the count stores
  always_comb begin
    unique case (cmd.tsel)
      TSEL_OLD: tsel_k = old_r;
      TSEL_K:   tsel_k = k_r;
      default:  tsel_k = new_r;
    endcase
  end

  logic [DTAW-1:0] dt_addr;
  logic [TTAW-1:0] tt_addr;
  assign dt_addr = {doc_r, tsel_k};
  assign tt_addr = {tsel_k, term_r};

  // clearing sweep over the count stores
  logic [CLRW-1:0] clr_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_r <= clr_r + CLRW'(1);
    end
  end

  // count and token stores
  logic [COUNT_BITS-1:0] dt_mem [2**DTAW];
  logic [COUNT_BITS-1:0] tt_mem [2**TTAW];
  logic [TW-1:0]         tok_mem [MAX_TOKENS];
  logic [COUNT_BITS-1:0] dt_q, tt_q, dt_upd, tt_upd;
  logic [TW-1:0]         tok_q;

  always_comb begin
    if (cmd.cnt_inc) begin
      dt_upd = (&dt_q) ? dt_q : dt_q + COUNT_BITS'(1);
      tt_upd = (&tt_q) ? tt_q : tt_q + COUNT_BITS'(1);
    end else begin
      dt_upd = (dt_q == '0) ? dt_q : dt_q - COUNT_BITS'(1);
      tt_upd = (tt_q == '0) ? tt_q : tt_q - COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      dt_mem[clr_r[DTAW-1:0]] <= '0;
      tt_mem[clr_r[TTAW-1:0]] <= '0;
    end else if (cmd.cnt_wr) begin
      dt_mem[dt_addr] <= dt_upd;
      tt_mem[tt_addr] <= tt_upd;
    end
    dt_q <= dt_mem[dt_addr];
    tt_q <= tt_mem[tt_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.tok_wr) begin
      tok_mem[tok_r] <= new_r;
    end
    tok_q <= tok_mem[tok_r];
  end

  // topic totals
  logic [TOTAL_W-1:0] tot_r [MAX_TOPICS];
  logic [TOTAL_W-1:0] tot_sel, tot_upd;
  assign tot_sel = tot_r[tsel_k];

  always_comb begin
    if (cmd.cnt_inc) begin
      tot_upd = (&tot_sel) ? tot_sel : tot_sel + TOTAL_W'(1);
    end else begin
      tot_upd = (tot_sel == '0) ? tot_sel : tot_sel - TOTAL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_TOPICS; i++) begin
        tot_r[i] <= '0;
      end
    end else if (cmd.cnt_wr) begin
      tot_r[tsel_k] <= tot_upd;
    end
  end

  // weight operands and split multiply
  logic [AW-1:0]      a_r, b_r;
  logic [DENW-1:0]    d_r;
  logic [NW-1:0]      prod_r;
  logic [AW+HB-1:0]   pp_lo;
  logic [NW-HB-1:0]   pp_hi;

  assign pp_lo = a_r * b_r[HB-1:0];
  assign pp_hi = a_r * b_r[AW-1:HB];

  always_ff @(posedge clk) begin
    if (cmd.w_load) begin
      a_r <= AW'({dt_q, {FRAC_SHIFT{1'b0}}}) + AW'(alpha_r);
      b_r <= AW'({tt_q, {FRAC_SHIFT{1'b0}}}) + AW'(beta_r);
      d_r <= DENW'({tot_sel, {FRAC_SHIFT{1'b0}}}) + DENW'(vb_r);
    end
    if (cmd.mul_lo) begin
      prod_r <= NW'(pp_lo);
    end else if (cmd.mul_hi) begin
      prod_r <= prod_r + {pp_hi, {HB{1'b0}}};
    end
  end

  // restoring divider, one quotient bit a cycle
  logic [DENW-1:0] rem_r;
  logic [NW-1:0]   quo_r;
  logic [DCW-1:0]  dcnt_r;
  logic [DENW:0]   trial, diff;
  logic            ge;

  assign trial = {rem_r, quo_r[NW-1]};
  assign diff  = trial - {1'b0, d_r};
  assign ge    = ~diff[DENW];

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem_r  <= '0;
      quo_r  <= prod_r;
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r  <= ge ? diff[DENW-1:0] : trial[DENW-1:0];
      quo_r  <= {quo_r[NW-2:0], ge};
      dcnt_r <= dcnt_r + DCW'(1);
    end
  end

  // saturated weight, zero for an empty denominator
  logic [QW-1:0]       wq;
  logic [WEIGHT_W-1:0] wsat;
  assign wq = QW'(quo_r);
  always_comb begin
    if (d_r == '0) begin
      wsat = '0;
    end else if (wq > QW'(WMAX)) begin
      wsat = WMAX;
    end else begin
      wsat = wq[WEIGHT_W-1:0];
    end
  end

  // weight buffer, running sums and threshold
  logic [WEIGHT_W-1:0] wbuf_r [MAX_TOPICS];
  logic [TSW-1:0]      total_r, run_r, run_nxt, thresh_r, thr_hi_r;
  logic [2*FRAC_W-1:0] thr_lo_r;
  logic                k_last, hit;
  logic [FRAC_W+KNW-1:0] init_prod;

  assign run_nxt   = run_r + TSW'(wbuf_r[k_r]);
  assign k_last    = {1'b0, k_r} == (kn - KNW'(1));
  assign hit       = (run_nxt > thresh_r) || k_last;
  assign init_prod = u_r * kn;

  always_ff @(posedge clk) begin
    if (cmd.w_store) begin
      wbuf_r[k_r] <= wsat;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.old_ld) begin
      old_r   <= tok_q;
      total_r <= '0;
    end
    if (cmd.k_clr) begin
      k_r   <= '0;
      run_r <= '0;
    end else if (cmd.w_store) begin
      k_r     <= k_r + TW'(1);
      total_r <= total_r + TSW'(wsat);
    end else if (cmd.srch_step) begin
      k_r   <= k_r + TW'(1);
      run_r <= run_nxt;
      if (hit) begin
        new_r <= k_r;
      end
    end
    if (cmd.init_calc) begin
      new_r <= init_prod[FRAC_W +: TW];
    end
    if (cmd.thr_mul) begin
      thr_hi_r <= total_r[TSW-1:FRAC_W] * u_r;
      thr_lo_r <= total_r[FRAC_W-1:0] * u_r;
    end
    if (cmd.thr_add) begin
      thresh_r <= thr_hi_r + TSW'(thr_lo_r[2*FRAC_W-1:FRAC_W]);
    end
  end

  // status and result
  assign sts.is_resample = (act_r == ACT_RESAMPLE);
  assign sts.clear_done  = &clr_r;
  assign sts.div_last    = (dcnt_r == DCW'(NW - 1));
  assign sts.k_last      = k_last;
  assign sts.hit         = hit;

  assign out_data.new_topic = TOPIC_W'(new_r);
  assign out_data.old_topic = (act_r == ACT_RESAMPLE) ? TOPIC_W'(old_r) : TOPIC_W'(new_r);

endmodule

// File: rtl/core/lda_gibbs_topic_resampler_unit.sv
// lda_gibbs_topic_resampler_unit: top level of the collapsed gibbs topic resampler
// joins the sequencer and the datapath
// depends on lgtr_pkg, lgtr_ctrl, lgtr_dpath
//
//  channel   ports                                      transaction when
//  input     start, busy, in_data                       start && !busy
//  result    out_valid, out_data                        out_valid (one cycle)
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data  cfg_valid && cfg_ready
//
// init item: S_TOK_RD, S_INIT, S_ADD_RD and S_ADD_WR, then the strobe in S_DONE
// resample item: removes the old topic, weighs each of the K active topics with
//   the bit-serial divider, forms the threshold and takes s <= K search steps
// after reset a clearing pass over 2**max(doc+topic, topic+term address bits)
//   words (65536 by default) zeroes the count stores; busy stays high meanwhile
// the receiver cannot stall; config writes are taken at any time
module lda_gibbs_topic_resampler_unit import lgtr_pkg::*; #(
  parameter int MAX_TOPICS = DEF_MAX_TOPICS,
  parameter int MAX_TERMS  = DEF_MAX_TERMS,
  parameter int MAX_DOCS   = DEF_MAX_DOCS,
  parameter int MAX_TOKENS = DEF_MAX_TOKENS,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  lgtr_in_t              in_data,
  output logic                  out_valid,
  output lgtr_out_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  lgtr_cmd_t    cmd;
  lgtr_status_t sts;

  assign cfg_ready = 1'b1;

  // sequencer
  lgtr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // datapath
  lgtr_dpath #(
    .MAX_TOPICS (MAX_TOPICS),
    .MAX_TERMS  (MAX_TERMS),
    .MAX_DOCS   (MAX_DOCS),
    .MAX_TOKENS (MAX_TOKENS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

  // result strobe is a single-cycle pulse
  a_single_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  // a result only comes while a transaction is in flight
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result strobe while idle");

  // an accepted transaction makes the unit busy and gives no instant result
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid)) else $error("accept did not start work");

endmodule
